// File: design/netascii_block_packetizer_unit_assert.svh
// ---------------------------------------------------------------------------
// netascii_block_packetizer_unit_assert.svh
// Assertion macros shared by the packetizer checker.
// ---------------------------------------------------------------------------
`ifndef NETASCII_BLOCK_PACKETIZER_UNIT_ASSERT_SVH
`define NETASCII_BLOCK_PACKETIZER_UNIT_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define NBPK_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("nbpk assertion failed");

// Next-cycle implication, sampled on clk, off during reset.
`define NBPK_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("nbpk assertion failed");

`endif

// File: design/nbpk_pkg.sv
// ---------------------------------------------------------------------------
// nbpk_pkg
// Types and constants of the netascii block packetizer.
// ---------------------------------------------------------------------------
package nbpk_pkg;

	localparam int BLOCK_BYTES = 512;
	localparam int FILL_W      = $clog2(BLOCK_BYTES);
	localparam int BLKNUM_W    = 16;
	localparam int QDEPTH      = 2;
	localparam int QPTR_W      = $clog2(QDEPTH);
	localparam int QCNT_W      = $clog2(QDEPTH + 1);

	localparam logic [FILL_W-1:0] FILL_LAST = FILL_W'(BLOCK_BYTES - 1);

	localparam logic [1:0] MODE_NETASCII = 2'd0;
	localparam logic [1:0] MODE_OCTET    = 2'd1;
	localparam logic [1:0] MODE_SINGLE   = 2'd2;

	localparam logic [7:0] CH_CR  = 8'h0D;
	localparam logic [7:0] CH_LF  = 8'h0A;
	localparam logic [7:0] CH_NUL = 8'h00;

	typedef enum logic [1:0] {
		CMD_BYTE,
		CMD_LF,
		CMD_CR,
		CMD_EOF
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t  kind;
		logic [7:0] data;
		logic       one_byte;
	} cmd_t;

	typedef enum logic {
		PH_FIRST,
		PH_SECOND
	} phase_t;

endpackage

// File: design/nbpk_queue.sv
// ---------------------------------------------------------------------------
// nbpk_queue
// Short command queue between the front and the back.
// ---------------------------------------------------------------------------
module nbpk_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_valid,
	input  nbpk_pkg::cmd_t push_cmd,
	output logic          push_ready,
	output logic          head_valid,
	output nbpk_pkg::cmd_t head_cmd,
	input  logic          pop
);
	import nbpk_pkg::*;

	cmd_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push;
	logic              do_pop;

	assign push_ready = (count_q != QCNT_W'(QDEPTH));
	assign head_valid = (count_q != '0);
	assign head_cmd   = mem_q[rd_ptr_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : QPTR_W'(wr_ptr_q + 1'b1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : QPTR_W'(rd_ptr_q + 1'b1);
			end
			unique case ({do_push, do_pop})
				2'b10:   count_q <= QCNT_W'(count_q + 1'b1);
				2'b01:   count_q <= QCNT_W'(count_q - 1'b1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

// File: design/nbpk_front.sv
// ---------------------------------------------------------------------------
// nbpk_front
// Mode register and request classifier.
// ---------------------------------------------------------------------------
module nbpk_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cfg_we,
	input  logic [1:0]     cfg_wdata,
	input  logic           func,
	input  logic [7:0]     data_byte,
	output nbpk_pkg::cmd_t cmd
);
	import nbpk_pkg::*;

	logic [1:0] mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_OCTET;
		end else if (cfg_we) begin
			mode_q <= cfg_wdata;
		end
	end

	always_comb begin
		cmd.data     = data_byte;
		cmd.one_byte = (mode_q == MODE_SINGLE);
		priority if (func) begin
			cmd.kind = CMD_EOF;
		end else if (mode_q == MODE_NETASCII && data_byte == CH_LF) begin
			cmd.kind = CMD_LF;
		end else if (mode_q == MODE_NETASCII && data_byte == CH_CR) begin
			cmd.kind = CMD_CR;
		end else begin
			cmd.kind = CMD_BYTE;
		end
	end

endmodule

// File: design/nbpk_back.sv
// ---------------------------------------------------------------------------
// nbpk_back
// Block sequencer: fill and block number, one result per cycle unless the output stalls.
// ---------------------------------------------------------------------------
module nbpk_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          head_valid,
	input  nbpk_pkg::cmd_t                head_cmd,
	output logic                          pop,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          byte_valid,
	output logic [7:0]                    out_byte,
	output logic [nbpk_pkg::BLKNUM_W-1:0] block_id,
	output logic                          packet_end,
	output logic                          last
);
	import nbpk_pkg::*;

	logic [FILL_W-1:0]   fill_q;
	logic [BLKNUM_W-1:0] blk_q;
	phase_t              phase_q;
	phase_t              phase_d;
	logic                out_valid_q;
	logic                byte_valid_q;
	logic [7:0]          out_byte_q;
	logic [BLKNUM_W-1:0] block_id_q;
	logic                packet_end_q;
	logic                last_q;

	logic                advance;
	logic                r_valid;
	logic [7:0]          r_byte;
	logic                r_end;
	logic                r_last;
	logic [FILL_W-1:0]   fill_d;
	logic [BLKNUM_W-1:0] blk_d;
	logic                at_last_slot;

	assign advance      = head_valid && (!out_valid_q || out_ready);
	assign at_last_slot = (fill_q >= FILL_LAST);

	// next phase of a CR/LF expansion
	always_comb begin
		phase_d = phase_q;
		if (head_cmd.kind == CMD_LF || head_cmd.kind == CMD_CR) begin
			unique case (phase_q)
				PH_FIRST:  phase_d = at_last_slot ? PH_FIRST : PH_SECOND;
				PH_SECOND: phase_d = PH_FIRST;
				default:   phase_d = PH_FIRST;
			endcase
		end
	end

	// result and state update
	always_comb begin
		r_valid = 1'b0;
		r_byte  = CH_NUL;
		r_end   = 1'b1;
		r_last  = 1'b0;
		pop     = 1'b0;
		fill_d  = '0;
		blk_d   = BLKNUM_W'(blk_q + 1'b1);
		unique case (head_cmd.kind)
			CMD_EOF: begin
				if (fill_q == '0) begin
					// zero-length block, numbering restarts
					r_last = 1'b1;
					pop    = 1'b1;
					blk_d  = BLKNUM_W'(1);
				end
			end
			CMD_LF, CMD_CR: begin
				if (phase_q == PH_FIRST) begin
					// byteless close if the pair would not fit
					if (!at_last_slot) begin
						r_valid = 1'b1;
						r_byte  = CH_CR;
						r_end   = 1'b0;
						fill_d  = FILL_W'(fill_q + 1'b1);
						blk_d   = blk_q;
					end
				end else begin
					r_valid = 1'b1;
					r_byte  = (head_cmd.kind == CMD_LF) ? CH_LF : CH_NUL;
					r_end   = at_last_slot;
					r_last  = 1'b1;
					pop     = 1'b1;
					if (!at_last_slot) begin
						fill_d = FILL_W'(fill_q + 1'b1);
						blk_d  = blk_q;
					end
				end
			end
			default: begin
				r_valid = 1'b1;
				r_byte  = head_cmd.data;
				r_end   = head_cmd.one_byte || at_last_slot;
				r_last  = 1'b1;
				pop     = 1'b1;
				if (!r_end) begin
					fill_d = FILL_W'(fill_q + 1'b1);
					blk_d  = blk_q;
				end
			end
		endcase
		if (!advance) begin
			pop = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			blk_q       <= BLKNUM_W'(1);
			phase_q     <= PH_FIRST;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			fill_q      <= fill_d;
			blk_q       <= blk_d;
			phase_q     <= phase_d;
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			byte_valid_q <= r_valid;
			out_byte_q   <= r_byte;
			block_id_q   <= blk_q;
			packet_end_q <= r_end;
			last_q       <= r_last;
		end
	end

	assign out_valid  = out_valid_q;
	assign byte_valid = byte_valid_q;
	assign out_byte   = out_byte_q;
	assign block_id   = block_id_q;
	assign packet_end = packet_end_q;
	assign last       = last_q;

endmodule

// File: design/netascii_block_packetizer_unit.sv
// ---------------------------------------------------------------------------
// netascii_block_packetizer_unit
// Cuts file bytes into numbered data blocks, netascii, octet or one-byte.
// ---------------------------------------------------------------------------
// Path: an accepted request goes through the queue, then the output register.
// Throughput: one result per cycle unless the output stalls; a plain byte
//   gives one result, a CR or LF in netascii two or three, EOF one or two.
// Reset: fill 0, block number 1, mode octet, queue and output register empty.
// ---------------------------------------------------------------------------
module netascii_block_packetizer_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration: transfer mode
	input  logic                          cfg_we,
	input  logic [1:0]                    cfg_wdata,
	// input requests
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          func,
	input  logic [7:0]                    data_byte,
	// result requests
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic                          byte_valid,
	output logic [7:0]                    out_byte,
	output logic [nbpk_pkg::BLKNUM_W-1:0] block_id,
	output logic                          packet_end,
	output logic                          last
);
	import nbpk_pkg::*;

	cmd_t front_cmd;
	cmd_t head_cmd;
	logic head_valid;
	logic pop;

	// Front: holds the mode and tags each request as plain byte, LF, CR or
	// end of file. Classification is combinational into the queue.
	nbpk_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.func      (func),
		.data_byte (data_byte),
		.cmd       (front_cmd)
	);

	// Queue: lets requests keep arriving while the back expands a CR/LF or
	// waits on a stalled output.
	nbpk_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (in_valid),
		.push_cmd   (front_cmd),
		.push_ready (in_ready),
		.head_valid (head_valid),
		.head_cmd   (head_cmd),
		.pop        (pop)
	);

	// Back: owns fill and block number; emits one result a cycle into its output
	// register unless stalled, and pops the queue on the request's final result.
	nbpk_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_cmd   (head_cmd),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.byte_valid (byte_valid),
		.out_byte   (out_byte),
		.block_id   (block_id),
		.packet_end (packet_end),
		.last       (last)
	);

endmodule

// File: design/nbpk_checker.sv
// ---------------------------------------------------------------------------
// nbpk_checker
// Port-level checks on the packetizer's result channel.
// ---------------------------------------------------------------------------
`include "netascii_block_packetizer_unit_assert.svh"

module nbpk_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic                          byte_valid,
	input logic [7:0]                    out_byte,
	input logic [nbpk_pkg::BLKNUM_W-1:0] block_id,
	input logic                          packet_end,
	input logic                          last
);
	import nbpk_pkg::*;

	logic [BLKNUM_W+10:0] res_bits;

	assign res_bits = {byte_valid, out_byte, block_id, packet_end, last};

	// a stalled result holds
	`NBPK_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(res_bits))

	// byteless results are always block closers
	`NBPK_ASSERT_NOW(a_marker_ends, out_valid && !byte_valid, packet_end)

	// byteless results carry a zero byte
	`NBPK_ASSERT_NOW(a_marker_zero, out_valid && !byte_valid, out_byte == CH_NUL)

endmodule

bind netascii_block_packetizer_unit nbpk_checker u_nbpk_checker (.*);

// File: bench/netascii_block_packetizer_unit_checker.sv
// ---------------------------------------------------------------------------
// netascii_block_packetizer_unit_checker
// Watches the request and result channels of the packetizer, predicts every
// result from the accepted requests and the transfer mode, and compares.
// ---------------------------------------------------------------------------
package nbpk_tb_pkg;

	localparam logic       FUNC_BYTE  = 1'b0;
	localparam logic       FUNC_EOF   = 1'b1;
	localparam logic [1:0] MODE_SPARE = 2'd3;

endpackage

module netascii_block_packetizer_unit_checker (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [1:0]                    cfg_wdata,
	input  logic                          in_valid,
	input  logic                          in_ready,
	input  logic                          func,
	input  logic [7:0]                    data_byte,
	input  logic                          out_valid,
	input  logic                          out_ready,
	input  logic                          byte_valid,
	input  logic [7:0]                    out_byte,
	input  logic [nbpk_pkg::BLKNUM_W-1:0] block_id,
	input  logic                          packet_end,
	input  logic                          last,
	output int unsigned                   results_due,
	output int unsigned                   fail_count
);
	timeunit 1ns;
	timeprecision 1ps;

	import nbpk_pkg::*;
	import nbpk_tb_pkg::*;

	typedef struct packed {
		logic                byte_valid;
		logic [7:0]          data;
		logic [BLKNUM_W-1:0] blk;
		logic                pkt_end;
		logic                last;
	} blk_result_t;

	blk_result_t         block_results_q[$];
	blk_result_t         held;
	bit                  have_held;
	logic [1:0]          mode;
	int unsigned         fill;
	logic [BLKNUM_W-1:0] blk_num;
	int unsigned         reported;

	// results of one request are held back by one so the final one can get last
	function automatic void emit(logic v, logic [7:0] b, logic pend);
		if (have_held)
			block_results_q.push_back(held);
		held.byte_valid = v;
		held.data       = v ? b : 8'h00;
		held.blk        = blk_num;
		held.pkt_end    = pend;
		held.last       = 1'b0;
		have_held       = 1'b1;
	endfunction

	function automatic void close_blk();
		fill    = 0;
		blk_num = blk_num + 1'b1;
	endfunction

	function automatic void place(logic [7:0] b, int unsigned limit);
		bit full;
		full = (fill + 1) >= limit;
		emit(1'b1, b, full);
		if (full)
			close_blk();
		else
			fill++;
	endfunction

	function automatic void packetize_request(logic f, logic [7:0] b);
		logic [7:0] second;
		if (f == FUNC_EOF) begin
			if (fill > 0) begin
				emit(1'b0, 8'h00, 1'b1);
				close_blk();
			end
			emit(1'b0, 8'h00, 1'b1);
			fill    = 0;
			blk_num = BLKNUM_W'(1);
		end else if (mode == MODE_NETASCII && (b == CH_LF || b == CH_CR)) begin
			second = (b == CH_LF) ? CH_LF : CH_NUL;
			// pair never split: close early when only one slot is left
			if (fill + 1 >= BLOCK_BYTES) begin
				emit(1'b0, 8'h00, 1'b1);
				close_blk();
			end
			place(CH_CR, BLOCK_BYTES);
			place(second, BLOCK_BYTES);
		end else begin
			place(b, (mode == MODE_SINGLE) ? 1 : BLOCK_BYTES);
		end
		held.last = 1'b1;
		block_results_q.push_back(held);
		have_held = 1'b0;
	endfunction

	always @(posedge clk or negedge arst_n) begin : monitor
		blk_result_t got;
		blk_result_t want;
		if (!arst_n) begin
			mode      = MODE_OCTET;
			fill      = 0;
			blk_num   = BLKNUM_W'(1);
			have_held = 1'b0;
			reported  = 0;
			fail_count = 0;
			block_results_q.delete();
			results_due <= 0;
		end else begin
			if (cfg_we)
				mode = cfg_wdata;
			if (in_valid && in_ready)
				packetize_request(func, data_byte);
			if (out_valid && out_ready) begin
				got = '{byte_valid, out_byte, block_id, packet_end, last};
				if (block_results_q.size() == 0) begin
					fail_count++;
					if (reported < 10) begin
						reported++;
						$display("unexpected result: bv=%0b byte=%02h blk=%0d end=%0b last=%0b",
							got.byte_valid, got.data, got.blk, got.pkt_end, got.last);
					end
				end else begin
					want = block_results_q.pop_front();
					if (got !== want) begin
						fail_count++;
						if (reported < 10) begin
							reported++;
							$display("mismatch: exp bv=%0b byte=%02h blk=%0d end=%0b last=%0b",
								want.byte_valid, want.data, want.blk, want.pkt_end, want.last);
							$display("          got bv=%0b byte=%02h blk=%0d end=%0b last=%0b",
								got.byte_valid, got.data, got.blk, got.pkt_end, got.last);
						end
					end
				end
			end
			results_due <= block_results_q.size();
		end
	end

endmodule

// File: bench/netascii_block_packetizer_unit_tb.sv
// ---------------------------------------------------------------------------
// netascii_block_packetizer_unit_tb
// Drives file bytes and end-of-file requests through the packetizer in all
// transfer modes, with random idling on both channels; the checker beside
// the block predicts and compares every result.
// ---------------------------------------------------------------------------
module netascii_block_packetizer_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import nbpk_pkg::*;
	import nbpk_tb_pkg::*;

	localparam int CLK_HALF        = 2;
	localparam int RX_HOLD_CYCLES  = 200;
	localparam int SETTLE_CYCLES   = 4;      // about the block's latency, plus margin
	localparam int RANDOM_REQUESTS = 40;
	localparam int TIMEOUT_NS      = 400_000;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                cfg_we;
	logic [1:0]          cfg_wdata;
	logic                in_valid;
	logic                in_ready;
	logic                func;
	logic [7:0]          data_byte;
	logic                out_valid;
	logic                out_ready;
	logic                byte_valid;
	logic [7:0]          out_byte;
	logic [BLKNUM_W-1:0] block_id;
	logic                packet_end;
	logic                last;

	int unsigned results_due;
	int unsigned fail_count;

	// stimulus knobs: fast sides never idle; the hold request parks the receiver
	bit tx_fast;
	bit rx_fast;
	bit rx_hold_req;

	always #CLK_HALF clk = ~clk;

	netascii_block_packetizer_unit i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.func       (func),
		.data_byte  (data_byte),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.byte_valid (byte_valid),
		.out_byte   (out_byte),
		.block_id   (block_id),
		.packet_end (packet_end),
		.last       (last)
	);

	netascii_block_packetizer_unit_checker i_chk (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.func        (func),
		.data_byte   (data_byte),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.byte_valid  (byte_valid),
		.out_byte    (out_byte),
		.block_id    (block_id),
		.packet_end  (packet_end),
		.last        (last),
		.results_due (results_due),
		.fail_count  (fail_count)
	);

	// -----------------------------------------------------------------------
	// Request side
	// -----------------------------------------------------------------------

	// Offers one request and returns at the edge that accepts it. Valid is
	// left high: the caller either puts the next request up or lowers it in
	// this same time step, so nothing is taken twice.
	task automatic send_req(input logic f, input logic [7:0] b);
		int gap;
		gap = tx_fast ? 0 : $urandom_range(0, 7);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid  <= 1'b1;
		func      <= f;
		data_byte <= b;
		// signals are all driven by NBA, so these reads see pre-edge values
		do @(posedge clk); while (!in_ready);
	endtask

	// any byte but CR and LF: fills a block without netascii expansion
	function automatic logic [7:0] plain_byte();
		logic [7:0] b;
		do b = 8'($urandom); while (b == CH_CR || b == CH_LF);
		return b;
	endfunction

	task automatic send_plain(input int n);
		repeat (n) send_req(FUNC_BYTE, plain_byte());
	endtask

	// end of file, with a junk data byte that must be ignored
	task automatic send_eof();
		send_req(FUNC_EOF, 8'($urandom));
	endtask

	// Sender pause: lower valid, wait until every predicted result is out,
	// then the settle time for the block.
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (results_due != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// mode register is only written with the block idle
	task automatic set_mode(input logic [1:0] m);
		drain();
		cfg_we    <= 1'b1;
		cfg_wdata <= m;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	// Random file: about a quarter of the bytes are CR or LF so netascii
	// expansions are frequent; the rest is any byte value.
	task automatic send_stream(input int len, input bit with_eof);
		int         pick;
		logic [7:0] b;
		for (int i = 0; i < len; i++) begin
			pick = $urandom_range(0, 7);
			b = (pick == 0) ? CH_CR : (pick == 1) ? CH_LF : 8'($urandom);
			send_req(FUNC_BYTE, b);
		end
		if (with_eof)
			send_eof();
	endtask

	// -----------------------------------------------------------------------
	// Result side: a random stall before each result, unless fast; once,
	// on request, a long hold-off so the block fills and stalls its input.
	// -----------------------------------------------------------------------
	initial begin
		int stall;
		out_ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			if (rx_hold_req) begin
				out_ready <= 1'b0;
				repeat (RX_HOLD_CYCLES) @(posedge clk);
				rx_hold_req = 1'b0;
			end else begin
				stall = rx_fast ? 0 : $urandom_range(0, 7);
				if (stall != 0) begin
					out_ready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	// -----------------------------------------------------------------------
	// Main sequence
	// -----------------------------------------------------------------------
	initial begin
		int sent;
		int len;
		bit hold_done;
		bit eof_too;

		arst_n      <= 1'b0;
		cfg_we      <= 1'b0;
		cfg_wdata   <= MODE_OCTET;
		in_valid    <= 1'b0;
		func        <= FUNC_BYTE;
		data_byte   <= 8'h00;
		tx_fast     = 1'b0;
		rx_fast     = 1'b0;
		rx_hold_req = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Directed part. Octet mode out of reset: CR and LF pass untouched,
		// then end of file on a partial block and on an empty one.
		send_req(FUNC_BYTE, 8'h00);
		send_req(FUNC_BYTE, 8'hFF);
		send_req(FUNC_BYTE, CH_CR);
		send_req(FUNC_BYTE, CH_LF);
		send_req(FUNC_EOF, 8'hFF);
		send_req(FUNC_EOF, 8'h00);

		// netascii: CR becomes CR NUL, LF becomes CR LF
		set_mode(MODE_NETASCII);
		send_req(FUNC_BYTE, 8'h41);
		send_req(FUNC_BYTE, CH_CR);
		send_req(FUNC_BYTE, CH_LF);
		send_req(FUNC_BYTE, CH_NUL);
		send_req(FUNC_BYTE, 8'hFF);
		send_eof();

		// one-byte blocks: every byte closes its block
		set_mode(MODE_SINGLE);
		send_req(FUNC_BYTE, 8'h80);
		send_req(FUNC_BYTE, CH_LF);
		send_eof();

		// unused mode code acts as octet
		set_mode(MODE_SPARE);
		send_req(FUNC_BYTE, 8'h7F);
		send_req(FUNC_BYTE, CH_CR);
		send_eof();

		// Long fill, back to back on both sides.
		tx_fast = 1'b1;
		rx_fast = 1'b1;

		// netascii: LF pairs up to one slot short of the last, a plain byte
		// into that slot, then a CR with one slot left, which closes the
		// block byteless and opens the next one with CR NUL
		set_mode(MODE_NETASCII);
		repeat (BLOCK_BYTES / 2 - 1) send_req(FUNC_BYTE, CH_LF);
		send_plain(1);
		send_req(FUNC_BYTE, CH_CR);
		send_eof();

		// octet: a partial block that becomes oversized for one-byte mode
		// and is closed by the next byte
		set_mode(MODE_OCTET);
		send_plain(3);
		set_mode(MODE_SINGLE);
		send_plain(1);
		set_mode(MODE_NETASCII);
		send_plain(2);
		send_eof();

		tx_fast = 1'b0;
		rx_fast = 1'b0;

		// Random part: short files in random modes, some left open so the
		// next mode change lands mid-block; the long hold-off comes once.
		sent      = 0;
		hold_done = 1'b0;
		while (sent < RANDOM_REQUESTS) begin
			if ($urandom_range(0, 4) == 0)
				set_mode(2'($urandom_range(0, 3)));
			tx_fast = ($urandom_range(0, 3) == 0);
			rx_fast = ($urandom_range(0, 3) == 0);
			if (!hold_done && sent >= RANDOM_REQUESTS / 3) begin
				// sender keeps offering while the receiver is parked
				hold_done   = 1'b1;
				rx_hold_req = 1'b1;
				tx_fast     = 1'b1;
				len         = 24;
			end else begin
				len = $urandom_range(0, 12);
			end
			eof_too = ($urandom_range(0, 3) != 0);
			send_stream(len, eof_too);
			sent += len + (eof_too ? 1 : 0);
			if ($urandom_range(0, 5) == 0)
				drain();
		end

		// wait out everything still predicted, then the settle time
		drain();
		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	// run limit, far above the slowest correct run
	initial begin
		#TIMEOUT_NS;
		$display("TB_ERROR");
		$finish;
	end

endmodule
